/* src/apf_pkg.sv */
// Shared types, constants and arithmetic helpers for the allpass phaser.
// No dependencies; imported by every module of the block.
package apf_pkg;

  localparam int CFG_AW = 5;

  // register indices (address bits [4:2])
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_LFO    = 3'd1;
  localparam logic [2:0] REG_DEPTH  = 3'd2;
  localparam logic [2:0] REG_FB     = 3'd3;
  localparam logic [2:0] REG_MIX    = 3'd4;

  localparam logic [16:0] UNIT16   = 17'd65536;
  localparam logic [15:0] FB_MAX   = 16'd58982;
  localparam logic [16:0] G_BASE   = 17'd13107;
  localparam logic [15:0] G_SPAN   = 16'd45875;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic signed [27:0] Q24_MAX = 28'sd8388607;
  localparam logic signed [27:0] Q24_MIN = -28'sd8388608;
  localparam logic signed [27:0] Q16_MAX = 28'sd32767;
  localparam logic signed [27:0] Q16_MIN = -28'sd32768;

  typedef struct packed {
    logic        effect_enable;
    logic [15:0] lfo_position;
    logic [16:0] mod_depth;
    logic [15:0] feedback_gain;
    logic [16:0] wet_mix;
  } cfg_regs_t;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > Q24_MAX) r = 24'sh7FFFFF;
    else if (v < Q24_MIN) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    logic signed [15:0] r;
    if (v > Q16_MAX) r = 16'sh7FFF;
    else if (v < Q16_MIN) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Q1.15 sine for a 32-bit turn fraction; quarter-wave Taylor series in Q2.30.
  // Only ever called with constant arguments (table build).
  function automatic logic signed [15:0] sine_q15(input logic [63:0] turn);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [15:0] s;
    quad = turn[31:30];
    r    = {34'd0, turn[29:0]};
    if (quad[0]) r = ONE_Q30 - r;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    t  = (x * t) >> 30;
    t  = (t + 64'd16384) >> 15;
    if (t > 64'd32767) t = 64'd32767;
    s = t[15:0];
    return quad[1] ? -s : s;
  endfunction

endpackage

/* src/apf_if.sv */
// Stream interfaces for the allpass phaser: sample input and sample result.
// Valid/ready handshake; no dependencies.
interface apf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  modport source(output valid, output sample_in, input ready);
  modport sink(input valid, input sample_in, output ready);
endinterface

interface apf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  modport source(output valid, output sample_out, input ready);
  modport sink(input valid, input sample_out, output ready);
endinterface

/* src/allpass_phaser_unit.sv */
// Allpass phaser: one sample in, one sample out, via a shared 25x18 multiplier.
// Processing runs sine read, coefficient, feedback, the sections in turn and the mix,
//   then loads the output register; bypass goes straight there. Next input taken as the sequencer idles.
// One sample is processed at a time, the single multiplier walking the sections (a
//   multiply and an accumulate state each) plus coefficient, feedback and mix steps.
// Reset (rst_n low, synchronous): registers to defaults, history cleared via valid bits.
module allpass_phaser_unit
  import apf_pkg::*;
#(
  parameter int STAGES       = 4,
  parameter int SINE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  apf_in_if.sink            in_chan,
  apf_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_SINE   = 12'b0000_0000_0010,  // sine table read settles
    S_UMUL   = 12'b0000_0000_0100,  // u * depth
    S_GMUL   = 12'b0000_0000_1000,  // span * v
    S_FBMUL  = 12'b0000_0001_0000,  // wet history * feedback; g latched
    S_X0     = 12'b0000_0010_0000,  // section input formed, first history read
    S_ST_MUL = 12'b0000_0100_0000,  // g * (yprev - x)
    S_ST_ACC = 12'b0000_1000_0000,  // section output, history write-back
    S_MIX_A  = 12'b0001_0000_0000,  // dry * (1 - mix)
    S_MIX_B  = 12'b0010_0000_0000,  // wet * mix
    S_MIX_C  = 12'b0100_0000_0000,  // sum, floor, saturate
    S_DONE   = 12'b1000_0000_0000   // wait for output slot
  } state_t;

  state_t state_r, state_nxt;

  cfg_regs_t regs;

  logic signed [15:0] sine_q;
  logic [15:0]        u;
  logic [16:0]        depth_sat;
  logic [15:0]        fb_sat;
  logic [16:0]        mix_sat;

  logic               in_acc;
  logic signed [15:0] dry_r;
  logic signed [23:0] x_r;
  logic signed [23:0] pin_r;
  logic signed [23:0] wet_r;
  logic [16:0]        g_r;
  logic [SW-1:0]      stage_r;
  logic               last_stage;

  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] prod_r;
  logic signed [42:0] acc_r;
  logic signed [43:0] mix_sum;

  logic signed [23:0] prev_out;
  logic signed [23:0] y;
  logic signed [23:0] x0;
  logic [47:0]        mem_q;
  logic               mem_we;
  logic [SW-1:0]      mem_raddr;

  logic signed [15:0] result_r;
  logic               out_valid_r;
  logic signed [15:0] out_data_r;
  logic               out_load;

  // ---------------------------------------------------------------------------
  // Register bank and sine table
  // ---------------------------------------------------------------------------
  apf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  apf_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_sine (
    .clk          (clk),
    .lfo_position (regs.lfo_position),
    .sine_q       (sine_q)
  );

  // registers above their range clamp
  assign depth_sat = (regs.mod_depth > UNIT16) ? UNIT16 : regs.mod_depth;
  assign fb_sat    = (regs.feedback_gain > FB_MAX) ? FB_MAX : regs.feedback_gain;
  assign mix_sat   = (regs.wet_mix > UNIT16) ? UNIT16 : regs.wet_mix;

  // (sine + 1) / 2 in Q0.16 from the Q1.15 value: flip the sign bit
  assign u = {~sine_q[15], sine_q[14:0]};

  // ---------------------------------------------------------------------------
  // Section history memory: {prev input, prev output} per section
  // ---------------------------------------------------------------------------
  assign mem_we    = (state_r == S_ST_ACC);
  assign mem_raddr = (state_r == S_ST_ACC && !last_stage) ? SW'(stage_r + 1'b1) : '0;

  apf_state_mem #(
    .STAGES (STAGES),
    .AW     (SW)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (stage_r),
    .wdata ({x_r, y}),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  assign prev_out   = mem_q[23:0];
  assign last_stage = (stage_r == SW'(STAGES - 1));

  // ---------------------------------------------------------------------------
  // Shared multiplier, operands picked by the sequencer, product registered
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_UMUL: begin
        mul_a = $signed({9'd0, u});
        mul_b = $signed({1'b0, depth_sat});
      end
      S_GMUL: begin
        mul_a = $signed({9'd0, G_SPAN});
        mul_b = $signed({2'b0, prod_r[31:16]});
      end
      S_FBMUL: begin
        mul_a = {wet_r[23], wet_r};
        mul_b = $signed({2'b0, fb_sat});
      end
      S_ST_MUL: begin
        mul_a = {prev_out[23], prev_out} - {x_r[23], x_r};
        mul_b = $signed({1'b0, g_r});
      end
      S_MIX_A: begin
        mul_a = {{9{dry_r[15]}}, dry_r};
        mul_b = $signed({1'b0, 17'(UNIT16 - mix_sat)});
      end
      S_MIX_B: begin
        mul_a = {x_r[23], x_r};
        mul_b = $signed({1'b0, mix_sat});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // all shifts are arithmetic, i.e. floor
  assign x0      = sat24(28'(dry_r) + {prod_r[42], prod_r[42:16]});
  assign y       = sat24(28'(pin_r) + {prod_r[42], prod_r[42:16]});
  assign mix_sum = 44'(acc_r) + 44'(prod_r);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = regs.effect_enable ? S_SINE : S_DONE;
      S_SINE:   state_nxt = S_UMUL;
      S_UMUL:   state_nxt = S_GMUL;
      S_GMUL:   state_nxt = S_FBMUL;
      S_FBMUL:  state_nxt = S_X0;
      S_X0:     state_nxt = S_ST_MUL;
      S_ST_MUL: state_nxt = S_ST_ACC;
      S_ST_ACC: state_nxt = last_stage ? S_MIX_A : S_ST_MUL;
      S_MIX_A:  state_nxt = S_MIX_B;
      S_MIX_B:  state_nxt = S_MIX_C;
      S_MIX_C:  state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stage_r <= '0;
      wet_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_X0) stage_r <= '0;
      else if (state_r == S_ST_ACC && !last_stage) stage_r <= SW'(stage_r + 1'b1);
      // wet history only moves on processed samples
      if (state_r == S_MIX_A) wet_r <= x_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_r    <= in_chan.sample_in;
      result_r <= in_chan.sample_in;  // bypass value; overwritten when processing
    end
    if (state_r == S_FBMUL)  g_r   <= G_BASE + {1'b0, prod_r[31:16]};
    if (state_r == S_X0)     x_r   <= x0;
    if (state_r == S_ST_MUL) pin_r <= mem_q[47:24];
    if (state_r == S_ST_ACC) x_r   <= y;
    if (state_r == S_MIX_B)  acc_r <= prod_r;
    if (state_r == S_MIX_C)  result_r <= sat16(mix_sum[43:16]);
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a finished result until its transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= result_r;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;

`ifndef SYNTHESIS
  // bypass: result is the input sample and the wet history is untouched
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !regs.effect_enable) |=>
      (state_r == S_DONE && result_r == $past(in_chan.sample_in) && $stable(wet_r)))
    else $error("bypass transfer altered result or state");

  // section counter never walks past the last section
  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r <= SW'(STAGES - 1))
    else $error("section counter out of range");

  // a finished result reaches the free output register on the next edge
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=>
      (out_valid_r && out_data_r == $past(result_r) && state_r == S_IDLE))
    else $error("result not moved to output register");
`endif

endmodule

/* src/apf_cfg.sv */
// APB-style register bank of the allpass phaser.
// Depends on apf_pkg.
module apf_cfg
  import apf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_regs_t         regs
);

  cfg_regs_t regs_r;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.effect_enable <= 1'b1;
      regs_r.lfo_position  <= 16'd0;
      regs_r.mod_depth     <= 17'd32768;
      regs_r.feedback_gain <= 16'd0;
      regs_r.wet_mix       <= 17'd32768;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_ENABLE: regs_r.effect_enable <= pwdata[0];
        REG_LFO:    regs_r.lfo_position  <= pwdata[15:0];
        REG_DEPTH:  regs_r.mod_depth     <= pwdata[16:0];
        REG_FB:     regs_r.feedback_gain <= pwdata[15:0];
        REG_MIX:    regs_r.wet_mix       <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ENABLE: prdata = {31'd0, regs_r.effect_enable};
      REG_LFO:    prdata = {16'd0, regs_r.lfo_position};
      REG_DEPTH:  prdata = {15'd0, regs_r.mod_depth};
      REG_FB:     prdata = {16'd0, regs_r.feedback_gain};
      REG_MIX:    prdata = {15'd0, regs_r.wet_mix};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

/* src/apf_sine_rom.sv */
// Sine lookup for the sweep: table built at elaboration, registered read.
// Depends on apf_pkg (sine_q15).
module apf_sine_rom
  import apf_pkg::*;
#(
  parameter int SINE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic [15:0]        lfo_position,
  output logic signed [15:0] sine_q
);

  localparam int IW = $clog2(SINE_ENTRIES);

  logic signed [15:0] rom [SINE_ENTRIES];
  logic [16+IW:0]     idx_prod;
  logic [IW-1:0]      idx;

  for (genvar i = 0; i < SINE_ENTRIES; i++) begin : g_rom
    localparam logic [63:0] TURN = (64'(i) << 32) / SINE_ENTRIES;
    assign rom[i] = sine_q15(TURN);
  end

  // index = lfo * entries >> 16, always below the table depth
  assign idx_prod = (17+IW)'(lfo_position) * (17+IW)'(SINE_ENTRIES);
  assign idx      = idx_prod[16 +: IW];

  always_ff @(posedge clk) begin
    sine_q <= rom[idx];
  end

endmodule

/* src/apf_state_mem.sv */
// Section history store: previous input and output of every allpass section.
// One write and one read port, read data registered; per-entry valid bits.
module apf_state_mem
  import apf_pkg::*;
#(
  parameter int STAGES = 4,
  parameter int AW     = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [47:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [47:0]   rdata
);

  logic [47:0]       mem [STAGES];
  logic [STAGES-1:0] valid_r;
  logic [47:0]       rd_data_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data_r <= mem[raddr];
  end

  // never-written entries read as zero history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (we) valid_r[waddr] <= 1'b1;
      rd_valid_r <= valid_r[raddr];
    end
  end

  assign rdata = rd_valid_r ? rd_data_r : 48'd0;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for allpass_phaser_unit: directed and random sample streams.
// An internal predictor tracks registers and filter state and checks each result transfer.
// Depends on src/apf_pkg.sv, src/apf_if.sv and the RTL of the block.
module testbench
  import apf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTION_COUNT = 4;
  localparam int SINE_POINTS   = 256;

  // Register indices that decode to nothing; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  localparam int TAIL_CYCLES   = 40;
  localparam int MAX_REPORTS   = 50;   // keep the log short if the block is badly off
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 50;

  logic clk;
  logic rst_n;

  apf_in_if  in_chan ();
  apf_out_if out_chan ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  allpass_phaser_unit #(
    .STAGES       (SECTION_COUNT),
    .SINE_ENTRIES (SINE_POINTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a copy of the register file and of the filter history.
  // ---------------------------------------------------------------------------
  cfg_regs_t phaser_cfg;
  longint    wet_feedback;                  // last wet sample, Q9.15
  longint    section_x1 [SECTION_COUNT];    // previous input of each allpass section
  longint    section_y1 [SECTION_COUNT];    // previous output of each allpass section

  logic [15:0] expected_samples [$];     // predicted results, oldest first
  int          mismatch_count;

  // Stimulus control
  bit                 steady_flow;       // suppress all idling on both sides
  int                 next_gap;          // idle cycles before the next input transfer
  logic signed [15:0] last_sample;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Slowest legal run is well under 2 ms; this is several times that.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Arithmetic of the predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Q1.15 sine of table point idx: quarter-wave Taylor series evaluated in Q2.30,
  // Horner form from the highest term down.
  function automatic int lfo_sine(input int unsigned idx);
    longint unsigned turn;
    longint unsigned frac;
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned acc;
    int unsigned     quadrant;
    int unsigned     denoms [5];
    denoms   = '{110, 72, 42, 20, 6};
    turn     = (longint'(idx) << 32) / SINE_POINTS;
    quadrant = int'((turn >> 30) & 3);
    frac     = turn & 64'h3FFF_FFFF;
    if (quadrant[0]) frac = ONE_Q30 - frac;
    ang    = (frac * HALF_PI_Q30) >> 30;
    ang_sq = (ang * ang) >> 30;
    acc    = ONE_Q30;
    foreach (denoms[k]) acc = ONE_Q30 - ((ang_sq * acc) >> 30) / denoms[k];
    acc = (ang * acc) >> 30;
    acc = (acc + 64'd16384) >> 15;
    if (acc > 64'd32767) acc = 64'd32767;
    return quadrant[1] ? -int'(acc) : int'(acc);
  endfunction

  // Processes one sample through the feedback loop, the allpass chain and the
  // dry/wet mix, updating the history. In bypass the sample comes straight back.
  function automatic logic [15:0] predict_phaser_sample(input logic signed [15:0] dry);
    longint depth;
    longint fb;
    longint mix;
    longint point;
    longint bias;
    longint coeff;
    longint x;
    longint y;
    longint mixed;
    if (!phaser_cfg.effect_enable) return dry;

    depth = clamp(longint'(phaser_cfg.mod_depth), 0, longint'(UNIT16));
    fb    = clamp(longint'(phaser_cfg.feedback_gain), 0, longint'(FB_MAX));
    mix   = clamp(longint'(phaser_cfg.wet_mix), 0, longint'(UNIT16));

    point = (longint'(phaser_cfg.lfo_position) * SINE_POINTS) >>> 16;
    if (point >= SINE_POINTS) point = SINE_POINTS - 1;
    bias  = longint'(lfo_sine(int'(point))) + 32768;
    bias  = (bias * depth) >>> 16;
    coeff = longint'(G_BASE) + ((longint'(G_SPAN) * bias) >>> 16);

    x = clamp(longint'(dry) + ((wet_feedback * fb) >>> 16),
              longint'(Q24_MIN), longint'(Q24_MAX));
    for (int s = 0; s < SECTION_COUNT; s++) begin
      y = clamp(section_x1[s] + ((coeff * (section_y1[s] - x)) >>> 16),
                longint'(Q24_MIN), longint'(Q24_MAX));
      section_x1[s] = x;
      section_y1[s] = y;
      x = y;
    end
    wet_feedback = x;

    mixed = (longint'(dry) * (longint'(UNIT16) - mix) + x * mix) >>> 16;
    mixed = clamp(mixed, -32768, 32767);
    return mixed[15:0];
  endfunction

  function automatic void restore_defaults();
    phaser_cfg.effect_enable = 1'b1;
    phaser_cfg.lfo_position  = 16'd0;
    phaser_cfg.mod_depth     = 17'd32768;
    phaser_cfg.feedback_gain = 16'd0;
    phaser_cfg.wet_mix       = 17'd32768;
    wet_feedback = 0;
    for (int s = 0; s < SECTION_COUNT; s++) begin
      section_x1[s] = 0;
      section_y1[s] = 0;
    end
  endfunction

  // Mostly short gaps, now and then a long one; none at all in steady stretches.
  function automatic int idle_cycles();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, each result transfer checked in order.
  // ---------------------------------------------------------------------------
  task automatic check_result(input logic [15:0] got);
    logic [15:0] want;
    if (expected_samples.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: result %0d with no sample outstanding", $time, $signed(got));
      return;
    end
    want = expected_samples.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: sample_out expected %0d, got %0d",
                 $time, $signed(want), $signed(got));
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_chan.ready = 1'b0;
        stall--;
      end else begin
        out_chan.ready = 1'b1;
        stall = idle_cycles();
      end
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) check_result(out_chan.sample_out);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and register port. All tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------

  // One input transfer. The gap before the following item is chosen here, so
  // valid stays high straight through back-to-back transfers.
  task automatic send_sample(input logic signed [15:0] smp);
    repeat (next_gap) @(negedge clk);
    in_chan.valid     = 1'b1;
    in_chan.sample_in = smp;
    do @(posedge clk); while (!in_chan.ready);
    expected_samples.push_back(predict_phaser_sample(smp));
    last_sample = smp;
    @(negedge clk);
    next_gap = idle_cycles();
    if (next_gap > 0) in_chan.valid = 1'b0;
  endtask

  // Closes a burst and waits until every result is back, so the block is idle.
  task automatic drain_block();
    if (next_gap == 0) in_chan.valid = 1'b0;
    next_gap = 0;
    while (expected_samples.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Setup then access phase; the register takes the value at the access edge.
  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {index, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_ENABLE: phaser_cfg.effect_enable = value[0];
      REG_LFO:    phaser_cfg.lfo_position  = value[15:0];
      REG_DEPTH:  phaser_cfg.mod_depth     = value[16:0];
      REG_FB:     phaser_cfg.feedback_gain = value[15:0];
      REG_MIX:    phaser_cfg.wet_mix       = value[16:0];
      default: ;  // unmapped index: no register changes
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_all(input logic en, input logic [15:0] lfo, input logic [16:0] depth,
                           input logic [15:0] fb, input logic [16:0] mix);
    write_register(REG_ENABLE, {31'd0, en});
    write_register(REG_LFO, {16'd0, lfo});
    write_register(REG_DEPTH, {15'd0, depth});
    write_register(REG_FB, {16'd0, fb});
    write_register(REG_MIX, {15'd0, mix});
  endtask

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 65535));
    if (r < 8) return 16'($urandom_range(0, 511) - 256);
    if (r < 9) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return last_sample;  // short DC runs let the feedback loop build up
  endfunction

  // Q0.16 gain with room above full scale: zero, unity, overrange or in range.
  function automatic logic [16:0] pick_unit_gain();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return UNIT16;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults straight out of reset, with full-scale and near-zero samples.
  task automatic test_reset_state();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    drain_block();
  endtask

  // Bypass returns the input untouched and must leave the filter history alone;
  // the samples after re-enabling show whether it did.
  task automatic test_bypass();
    write_register(REG_ENABLE, 32'd0);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    drain_block();
    // writes to unmapped indices must not disturb anything
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_register(i[2:0], 32'hFFFF_FFFF);
    write_register(REG_ENABLE, 32'd1);
    send_sample(16'sd1);
    send_sample(16'sh4000);
    drain_block();
  endtask

  // Register extremes, overrange values that must saturate, and a full-scale DC
  // run at maximum feedback and full wet mix to drive the output into clipping.
  task automatic test_register_extremes();
    write_all(1'b1, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 17'h1FFFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain_block();
    write_all(1'b1, 16'h0000, 17'd0, 16'd0, 17'd0);
    send_sample(16'sh1234);
    drain_block();
    write_all(1'b1, 16'h4000, UNIT16, 16'd0, UNIT16);
    send_sample(-16'sd12345);
    drain_block();
    write_all(1'b1, 16'hC000, UNIT16, FB_MAX, UNIT16);
    repeat (12) send_sample(16'sh7FFF);
    drain_block();
  endtask

  // Random register settings per phase, with random samples in between. Every
  // fourth phase runs without any idling on either side.
  task automatic test_random_phases();
    logic [15:0] lfo;
    logic [15:0] fb;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady_flow = (phase % 4 == 1);
      case ($urandom_range(0, 4))
        0:       lfo = 16'h0000;
        1:       lfo = 16'hFFFF;
        default: lfo = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 9))
        0:       fb = 16'd0;
        1:       fb = FB_MAX;
        2:       fb = 16'($urandom_range(58983, 65535));
        default: fb = 16'($urandom_range(0, 58982));
      endcase
      write_all($urandom_range(0, 9) != 0, lfo, pick_unit_gain(), fb, pick_unit_gain());
      if ($urandom_range(0, 3) == 0)
        write_register(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      drain_block();
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.sample_in = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mismatch_count    = 0;
    steady_flow       = 1'b0;
    next_gap          = 0;
    last_sample       = '0;
    restore_defaults();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_bypass();
    test_register_extremes();
    test_random_phases();

    // nothing outstanding now; leave room for any stray result transfer
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
src/apf_pkg.sv
src/apf_if.sv
src/apf_cfg.sv
src/apf_sine_rom.sv
src/apf_state_mem.sv
src/allpass_phaser_unit.sv
dv/testbench.sv
